>>> design/bpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpr_pkg: shared constants for the buffer pool replacement block
// Sizes of the frame table and of the payload fields, operation codes and
// status codes.
// ----------------------------------------------------------------------------
package bpr_pkg;

  // frame table
  localparam int FRAMES   = 8;
  localparam int FRAME_W  = $clog2(FRAMES);
  localparam int PIN_BITS = 16;

  // payload fields
  localparam int OP_W     = 3;
  localparam int PAGE_W   = 31;
  localparam int STAT_W   = 2;
  localparam int FIDX_W   = 3;
  localparam int CNT_W    = 32;

  // configuration port
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // operations
  localparam logic [OP_W-1:0] OP_PIN   = 3'd0;
  localparam logic [OP_W-1:0] OP_UNPIN = 3'd1;
  localparam logic [OP_W-1:0] OP_DIRTY = 3'd2;
  localparam logic [OP_W-1:0] OP_FORCE = 3'd3;
  localparam logic [OP_W-1:0] OP_FLUSH = 3'd4;

  // result status
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_RES = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_FREE = 2'd2;

endpackage

>>> design/buffer_pool_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buffer_pool_replacement: page frame manager with FIFO / LRU replacement
// Frame table in flops, walked one frame per cycle by a small sequencer that
// shares one compare/update slice over all frames.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                    payload
//  --------  ---------  ---------------------------  --------------------------
//  in        sink       in_valid_i / in_ready_o      operation_i, page_number_i
//  out       source     out_valid_o / out_ready_i    status_o .. write_total_o
//  cfg       APB slave  psel/penable/pwrite, pready  paddr, pwdata, prdata
//
//  Steps: pin, unpin, mark dirty and force page run a lookup walk over all
//  frames, a decide step, an update walk over all frames and an emit; a miss on
//  unpin/dirty/force or a full pool skips the update walk. Flush with k
//  eligible frames runs k+1 flush walks, each followed by a decision step,
//  plus one emit per result. Unknown operation codes return to idle with no
//  result.
//  in_ready_o is high only while the sequencer is idle; a result waiting in
//  the output register does not block the next transfer in, only the next
//  emit. Reset is asynchronous, active low; it frees all frames and restores
//  identity replacement order. No clearing pass is needed.
//
module buffer_pool_replacement (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // item in
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [bpr_pkg::OP_W-1:0]    operation_i,
  input  logic [bpr_pkg::PAGE_W-1:0]  page_number_i,
  // result out
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bpr_pkg::STAT_W-1:0]  status_o,
  output logic [bpr_pkg::FIDX_W-1:0]  frame_index_o,
  output logic                        read_request_o,
  output logic [bpr_pkg::PAGE_W-1:0]  read_page_o,
  output logic                        write_request_o,
  output logic [bpr_pkg::PAGE_W-1:0]  write_page_o,
  output logic                        last_o,
  output logic [bpr_pkg::CNT_W-1:0]   read_total_o,
  output logic [bpr_pkg::CNT_W-1:0]   write_total_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpr_pkg::APB_AW-1:0]  paddr,
  input  logic [bpr_pkg::APB_DW-1:0]  pwdata,
  output logic [bpr_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import bpr_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;  // wait for an input transfer
  localparam logic [2:0] S_SCAN  = 3'd1;  // lookup walk: hit, free, victim
  localparam logic [2:0] S_DEC   = 3'd2;  // pick target frame
  localparam logic [2:0] S_UPD   = 3'd3;  // update walk: ranks + target frame
  localparam logic [2:0] S_EMIT  = 3'd4;  // push result into output register
  localparam logic [2:0] S_FSCAN = 3'd5;  // flush walk: next oldest dirty
  localparam logic [2:0] S_FDEC  = 3'd6;  // flush decision

  localparam logic [FRAME_W-1:0] LAST_IDX = FRAME_W'(FRAMES - 1);

  // frame table
  logic [PAGE_W-1:0]   page_q  [FRAMES];
  logic [PAGE_W-1:0]   page_d  [FRAMES];
  logic [FRAMES-1:0]   valid_q, valid_d;
  logic [FRAMES-1:0]   dirty_q, dirty_d;
  logic [PIN_BITS-1:0] pins_q  [FRAMES];
  logic [PIN_BITS-1:0] pins_d  [FRAMES];
  logic [FRAME_W-1:0]  rank_q  [FRAMES];
  logic [FRAME_W-1:0]  rank_d  [FRAMES];

  logic                lru_q;

  // sequencer
  logic [2:0]          state_q, state_d;
  logic [FRAME_W-1:0]  idx_q, idx_d;
  logic [OP_W-1:0]     op_q, op_d;
  logic [PAGE_W-1:0]   req_pg_q, req_pg_d;

  // lookup trackers
  logic                hit_q, hit_d;
  logic [FRAME_W-1:0]  hit_idx_q, hit_idx_d;
  logic [FRAME_W-1:0]  hit_rk_q, hit_rk_d;
  logic                free_q, free_d;
  logic [FRAME_W-1:0]  free_idx_q, free_idx_d;
  logic [FRAME_W-1:0]  free_rk_q, free_rk_d;
  logic                ev_q, ev_d;          // victim / flush candidate
  logic [FRAME_W-1:0]  ev_idx_q, ev_idx_d;
  logic [FRAME_W-1:0]  ev_rk_q, ev_rk_d;
  logic [PAGE_W-1:0]   ev_pg_q, ev_pg_d;

  // target of the update walk
  logic [FRAME_W-1:0]  tgt_q, tgt_d;
  logic [FRAME_W-1:0]  tgt_rk_q, tgt_rk_d;
  logic                mv_q, mv_d;          // move target to back of order
  logic                load_q, load_d;      // pin fills the target frame

  // flush bookkeeping: frame found by the previous walk, result still owed
  logic                prev_q, prev_d;
  logic [FRAME_W-1:0]  prev_idx_q, prev_idx_d;
  logic [PAGE_W-1:0]   prev_pg_q, prev_pg_d;
  logic                cont_q, cont_d;

  // pending result
  logic [STAT_W-1:0]   res_stat_q, res_stat_d;
  logic [FRAME_W-1:0]  res_frame_q, res_frame_d;
  logic                res_rd_q, res_rd_d;
  logic                res_wr_q, res_wr_d;
  logic [PAGE_W-1:0]   res_wpg_q, res_wpg_d;
  logic                res_last_q, res_last_d;

  // counters and output register
  logic [CNT_W-1:0]    rd_tot_q, rd_tot_d;
  logic [CNT_W-1:0]    wr_tot_q, wr_tot_d;
  logic                ov_q, ov_d;
  logic [STAT_W-1:0]   o_stat_q, o_stat_d;
  logic [FIDX_W-1:0]   o_frame_q, o_frame_d;
  logic                o_rd_q, o_rd_d;
  logic [PAGE_W-1:0]   o_rpg_q, o_rpg_d;
  logic                o_wr_q, o_wr_d;
  logic [PAGE_W-1:0]   o_wpg_q, o_wpg_d;
  logic                o_last_q, o_last_d;

  // the frame under the walk pointer
  logic [PAGE_W-1:0]   cur_pg;
  logic                cur_vl, cur_dt, cur_unpinned, cur_excl;
  logic [PIN_BITS-1:0] cur_pn;
  logic [FRAME_W-1:0]  cur_rk;

  assign cur_pg       = page_q[idx_q];
  assign cur_vl       = valid_q[idx_q];
  assign cur_dt       = dirty_q[idx_q];
  assign cur_pn       = pins_q[idx_q];
  assign cur_rk       = rank_q[idx_q];
  assign cur_unpinned = (cur_pn == '0);
  assign cur_excl     = prev_q && (idx_q == prev_idx_q);

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (!paddr[2]) begin
      prdata = APB_DW'(lru_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lru_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      lru_q <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------- ports
  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = ov_q;
  assign status_o        = o_stat_q;
  assign frame_index_o   = o_frame_q;
  assign read_request_o  = o_rd_q;
  assign read_page_o     = o_rpg_q;
  assign write_request_o = o_wr_q;
  assign write_page_o    = o_wpg_q;
  assign last_o          = o_last_q;
  assign read_total_o    = rd_tot_q;
  assign write_total_o   = wr_tot_q;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    page_d     = page_q;
    valid_d    = valid_q;
    dirty_d    = dirty_q;
    pins_d     = pins_q;
    rank_d     = rank_q;
    state_d    = state_q;
    idx_d      = idx_q;
    op_d       = op_q;
    req_pg_d   = req_pg_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_rk_d   = hit_rk_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    free_rk_d  = free_rk_q;
    ev_d       = ev_q;
    ev_idx_d   = ev_idx_q;
    ev_rk_d    = ev_rk_q;
    ev_pg_d    = ev_pg_q;
    tgt_d      = tgt_q;
    tgt_rk_d   = tgt_rk_q;
    mv_d       = mv_q;
    load_d     = load_q;
    prev_d     = prev_q;
    prev_idx_d = prev_idx_q;
    prev_pg_d  = prev_pg_q;
    cont_d     = cont_q;
    res_stat_d = res_stat_q;
    res_frame_d = res_frame_q;
    res_rd_d   = res_rd_q;
    res_wr_d   = res_wr_q;
    res_wpg_d  = res_wpg_q;
    res_last_d = res_last_q;
    rd_tot_d   = rd_tot_q;
    wr_tot_d   = wr_tot_q;
    ov_d       = ov_q;
    o_stat_d   = o_stat_q;
    o_frame_d  = o_frame_q;
    o_rd_d     = o_rd_q;
    o_rpg_d    = o_rpg_q;
    o_wr_d     = o_wr_q;
    o_wpg_d    = o_wpg_q;
    o_last_d   = o_last_q;

    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = operation_i;
          req_pg_d = page_number_i;
          idx_d    = '0;
          hit_d    = 1'b0;
          free_d   = 1'b0;
          ev_d     = 1'b0;
          prev_d   = 1'b0;
          unique case (operation_i) inside
            OP_PIN, OP_UNPIN, OP_DIRTY, OP_FORCE: state_d = S_SCAN;
            OP_FLUSH:                             state_d = S_FSCAN;
            default:                              state_d = S_IDLE;
          endcase
        end
      end

      S_SCAN: begin
        if (!hit_q && cur_vl && (cur_pg == req_pg_q)) begin
          hit_d     = 1'b1;
          hit_idx_d = idx_q;
          hit_rk_d  = cur_rk;
        end
        if (!cur_vl && (!free_q || (cur_rk < free_rk_q))) begin
          free_d     = 1'b1;
          free_idx_d = idx_q;
          free_rk_d  = cur_rk;
        end
        if (cur_vl && cur_unpinned && (!ev_q || (cur_rk < ev_rk_q))) begin
          ev_d     = 1'b1;
          ev_idx_d = idx_q;
          ev_rk_d  = cur_rk;
        end
        if (idx_q == LAST_IDX) begin
          state_d = S_DEC;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_DEC: begin
        res_stat_d  = STAT_OK;
        res_frame_d = '0;
        res_rd_d    = 1'b0;
        res_wr_d    = 1'b0;
        res_wpg_d   = '0;
        res_last_d  = 1'b1;
        cont_d      = 1'b0;
        mv_d        = 1'b0;
        load_d      = 1'b0;
        idx_d       = '0;
        state_d     = S_UPD;
        if (hit_q) begin
          tgt_d    = hit_idx_q;
          tgt_rk_d = hit_rk_q;
          mv_d     = (op_q == OP_PIN) && lru_q;
        end else if (op_q != OP_PIN) begin
          res_stat_d = STAT_NOT_RES;
          state_d    = S_EMIT;
        end else if (free_q) begin
          tgt_d    = free_idx_q;
          tgt_rk_d = free_rk_q;
          mv_d     = 1'b1;
          load_d   = 1'b1;
        end else if (ev_q) begin
          tgt_d    = ev_idx_q;
          tgt_rk_d = ev_rk_q;
          mv_d     = 1'b1;
          load_d   = 1'b1;
        end else begin
          res_stat_d = STAT_NO_FREE;
          state_d    = S_EMIT;
        end
        if (state_d == S_UPD) begin
          res_frame_d = tgt_d;
        end
      end

      S_UPD: begin
        // close the gap left by the target, target goes to the back
        if (mv_q && (cur_rk > tgt_rk_q)) begin
          rank_d[idx_q] = cur_rk - 1'b1;
        end
        if (idx_q == tgt_q) begin
          if (mv_q) begin
            rank_d[idx_q] = LAST_IDX;
          end
          case (op_q)
            OP_PIN: begin
              if (load_q) begin
                if (cur_dt) begin
                  res_wr_d  = 1'b1;
                  res_wpg_d = cur_pg;
                end
                page_d[idx_q]  = req_pg_q;
                valid_d[idx_q] = 1'b1;
                dirty_d[idx_q] = 1'b0;
                pins_d[idx_q]  = PIN_BITS'(1);
                res_rd_d       = 1'b1;
              end else if (cur_pn != '1) begin
                pins_d[idx_q] = cur_pn + 1'b1;
              end
            end
            OP_UNPIN: begin
              if (!cur_unpinned) begin
                pins_d[idx_q] = cur_pn - 1'b1;
              end
            end
            OP_DIRTY: dirty_d[idx_q] = 1'b1;
            OP_FORCE: begin
              dirty_d[idx_q] = 1'b0;
              res_wr_d       = 1'b1;
              res_wpg_d      = cur_pg;
            end
            default: ;
          endcase
        end
        if (idx_q == LAST_IDX) begin
          state_d = S_EMIT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_EMIT: begin
        if (!ov_q || out_ready_i) begin
          rd_tot_d  = rd_tot_q + CNT_W'(res_rd_q);
          wr_tot_d  = wr_tot_q + CNT_W'(res_wr_q);
          ov_d      = 1'b1;
          o_stat_d  = res_stat_q;
          o_frame_d = FIDX_W'(res_frame_q);
          o_rd_d    = res_rd_q;
          o_rpg_d   = res_rd_q ? req_pg_q : '0;
          o_wr_d    = res_wr_q;
          o_wpg_d   = res_wpg_q;
          o_last_d  = res_last_q;
          if ((op_q == OP_FLUSH) && cont_q) begin
            idx_d   = '0;
            ev_d    = 1'b0;
            state_d = S_FSCAN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      S_FSCAN: begin
        // the frame found by the previous walk gets its dirty bit cleared here
        if (cur_excl) begin
          dirty_d[idx_q] = 1'b0;
        end
        if (cur_vl && cur_dt && cur_unpinned && !cur_excl &&
            (!ev_q || (cur_rk < ev_rk_q))) begin
          ev_d     = 1'b1;
          ev_idx_d = idx_q;
          ev_rk_d  = cur_rk;
          ev_pg_d  = cur_pg;
        end
        if (idx_q == LAST_IDX) begin
          state_d = S_FDEC;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_FDEC: begin
        res_stat_d  = STAT_OK;
        res_frame_d = '0;
        res_rd_d    = 1'b0;
        res_wr_d    = 1'b0;
        res_wpg_d   = '0;
        res_last_d  = 1'b1;
        cont_d      = 1'b0;
        prev_d      = ev_q;
        prev_idx_d  = ev_idx_q;
        prev_pg_d   = ev_pg_q;
        if (prev_q) begin
          // report the previous frame; last only if nothing else is left
          res_frame_d = prev_idx_q;
          res_wr_d    = 1'b1;
          res_wpg_d   = prev_pg_q;
          res_last_d  = !ev_q;
          cont_d      = ev_q;
          state_d     = S_EMIT;
        end else if (ev_q) begin
          idx_d   = '0;
          ev_d    = 1'b0;
          state_d = S_FSCAN;
        end else begin
          state_d = S_EMIT;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      valid_q  <= '0;
      dirty_q  <= '0;
      for (int f = 0; f < FRAMES; f++) begin
        pins_q[f] <= '0;
        rank_q[f] <= FRAME_W'(f);
      end
      idx_q    <= '0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      ev_q     <= 1'b0;
      mv_q     <= 1'b0;
      load_q   <= 1'b0;
      prev_q   <= 1'b0;
      cont_q   <= 1'b0;
      res_rd_q <= 1'b0;
      res_wr_q <= 1'b0;
      rd_tot_q <= '0;
      wr_tot_q <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      dirty_q  <= dirty_d;
      pins_q   <= pins_d;
      rank_q   <= rank_d;
      idx_q    <= idx_d;
      hit_q    <= hit_d;
      free_q   <= free_d;
      ev_q     <= ev_d;
      mv_q     <= mv_d;
      load_q   <= load_d;
      prev_q   <= prev_d;
      cont_q   <= cont_d;
      res_rd_q <= res_rd_d;
      res_wr_q <= res_wr_d;
      rd_tot_q <= rd_tot_d;
      wr_tot_q <= wr_tot_d;
      ov_q     <= ov_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    page_q      <= page_d;
    op_q        <= op_d;
    req_pg_q    <= req_pg_d;
    hit_idx_q   <= hit_idx_d;
    hit_rk_q    <= hit_rk_d;
    free_idx_q  <= free_idx_d;
    free_rk_q   <= free_rk_d;
    ev_idx_q    <= ev_idx_d;
    ev_rk_q     <= ev_rk_d;
    ev_pg_q     <= ev_pg_d;
    tgt_q       <= tgt_d;
    tgt_rk_q    <= tgt_rk_d;
    prev_idx_q  <= prev_idx_d;
    prev_pg_q   <= prev_pg_d;
    res_stat_q  <= res_stat_d;
    res_frame_q <= res_frame_d;
    res_wpg_q   <= res_wpg_d;
    res_last_q  <= res_last_d;
    o_stat_q    <= o_stat_d;
    o_frame_q   <= o_frame_d;
    o_rd_q      <= o_rd_d;
    o_rpg_q     <= o_rpg_d;
    o_wr_q      <= o_wr_d;
    o_wpg_q     <= o_wpg_d;
    o_last_q    <= o_last_d;
  end

endmodule

>>> bench/buffer_pool_replacement_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buffer_pool_replacement_tb: self-checking bench for the frame manager
// Drives pin, unpin, mark-dirty, force-page and flush-pool requests into the
// block under both replacement strategies. A shadow frame table predicts
// every result, and a monitor checks each result transfer field by field
// in order. The sender runs in random bursts, and the result side stalls
// on its own pattern, including one long hold-off that backs the block up.
// ----------------------------------------------------------------------------
module buffer_pool_replacement_tb;
  import bpr_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 48;      // > one full lookup + update walk
  localparam int HOLD_CYCLES   = 400;     // long result-side hold-off
  localparam int HOT_PAGES     = 12;
  localparam int MAX_REPORTS   = 10;

  // register map: strategy_lru is register 0 at byte address 0
  localparam logic [APB_AW-1:0] REG_STRATEGY = '0;

  // op codes above flush are ignored by the block
  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_FLUSH + 1'b1;
  localparam logic [OP_W-1:0] OP_LAST_CODE    = '1;

  localparam logic [PAGE_W-1:0] PAGE_LOW  = '0;
  localparam logic [PAGE_W-1:0] PAGE_HIGH = '1;
  localparam logic [PAGE_W-1:0] PAGE_ALT  = 31'h5555_5555;
  localparam logic [PAGE_W-1:0] PAGE_ALTN = 31'h2AAA_AAAA;

  typedef enum int {READY_ALWAYS, READY_PATTERN, READY_SPARSE} ready_mode_e;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [FIDX_W-1:0] frame_index;
    logic              rd_req;
    logic [PAGE_W-1:0] rd_page;
    logic              wr_req;
    logic [PAGE_W-1:0] wr_page;
    logic              last;
    logic [CNT_W-1:0]  rd_total;
    logic [CNT_W-1:0]  wr_total;
  } frame_result_t;

  // --------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [OP_W-1:0]     operation_i   = '0;
  logic [PAGE_W-1:0]   page_number_i = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [STAT_W-1:0]   status_o;
  logic [FIDX_W-1:0]   frame_index_o;
  logic                read_request_o;
  logic [PAGE_W-1:0]   read_page_o;
  logic                write_request_o;
  logic [PAGE_W-1:0]   write_page_o;
  logic                last_o;
  logic [CNT_W-1:0]    read_total_o;
  logic [CNT_W-1:0]    write_total_o;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [APB_AW-1:0]   paddr         = '0;
  logic [APB_DW-1:0]   pwdata        = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  buffer_pool_replacement u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .page_number_i   (page_number_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .frame_index_o   (frame_index_o),
    .read_request_o  (read_request_o),
    .read_page_o     (read_page_o),
    .write_request_o (write_request_o),
    .write_page_o    (write_page_o),
    .last_o          (last_o),
    .read_total_o    (read_total_o),
    .write_total_o   (write_total_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Shadow frame table, updated in transfer order on the input side
  // --------------------------------------------------------------------------
  logic [PAGE_W-1:0]   shadow_page  [FRAMES];
  logic                shadow_valid [FRAMES];
  logic                shadow_dirty [FRAMES];
  logic [PIN_BITS-1:0] shadow_pins  [FRAMES];
  logic [FRAME_W-1:0]  shadow_rank  [FRAMES];  // 0 = next victim
  logic [CNT_W-1:0]    reads_total;
  logic [CNT_W-1:0]    writes_total;
  logic                lru_mode;

  frame_result_t       pending_results[$];

  // bookkeeping
  int                  failures        = 0;
  int                  results_checked = 0;
  int                  transfers_in    = 0;
  int                  ignored_ops     = 0;
  int                  burst_left      = 0;
  int                  cycle_count     = 0;
  logic [PAGE_W-1:0]   hot_pages[HOT_PAGES];

  event                hold_off_go;
  logic                hold_active = 1'b0;

  function automatic void report_failure(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("%t ERROR %s", $realtime, msg);
  endfunction

  function automatic void clear_shadow_table();
    for (int f = 0; f < FRAMES; f++) begin
      shadow_page[f]  = '0;
      shadow_valid[f] = 1'b0;
      shadow_dirty[f] = 1'b0;
      shadow_pins[f]  = '0;
      shadow_rank[f]  = FRAME_W'(f);
    end
    reads_total  = '0;
    writes_total = '0;
    lru_mode     = 1'b0;
  endfunction

  // lowest frame index wins if a page were ever resident twice
  function automatic int find_resident(input logic [PAGE_W-1:0] page);
    for (int f = 0; f < FRAMES; f++) begin
      if (shadow_valid[f] && shadow_page[f] == page) return f;
    end
    return -1;
  endfunction

  // oldest free frame, or oldest resident unpinned frame
  function automatic int oldest_frame(input bit want_free);
    int best;
    bit ok;
    best = -1;
    for (int f = 0; f < FRAMES; f++) begin
      ok = want_free ? !shadow_valid[f] : (shadow_valid[f] && shadow_pins[f] == '0);
      if (ok && (best < 0 || shadow_rank[f] < shadow_rank[best])) best = f;
    end
    return best;
  endfunction

  function automatic void move_to_back(input int f);
    for (int g = 0; g < FRAMES; g++) begin
      if (shadow_rank[g] > shadow_rank[f]) shadow_rank[g]--;
    end
    shadow_rank[f] = FRAME_W'(FRAMES - 1);
  endfunction

  // totals are taken after the caller has counted this result's requests
  function automatic void push_result(input logic [STAT_W-1:0] st, input int f,
                                      input logic rd, input logic [PAGE_W-1:0] rpage,
                                      input logic wr, input logic [PAGE_W-1:0] wpage,
                                      input logic last);
    frame_result_t r;
    r.status      = st;
    r.frame_index = FIDX_W'(f);
    r.rd_req      = rd;
    r.rd_page     = rpage;
    r.wr_req      = wr;
    r.wr_page     = wpage;
    r.last        = last;
    r.rd_total    = reads_total;
    r.wr_total    = writes_total;
    pending_results.push_back(r);
  endfunction

  // Apply one accepted request to the shadow table and queue its results.
  function automatic void predict_frame_op(input logic [OP_W-1:0] op,
                                           input logic [PAGE_W-1:0] page);
    int f;
    logic wr;
    logic [PAGE_W-1:0] wpage;
    int flush_list[$];

    if (op == OP_PIN) begin
      f = find_resident(page);
      if (f >= 0) begin
        // hit: saturating pin count, LRU refreshes the frame's age
        if (shadow_pins[f] != {PIN_BITS{1'b1}}) shadow_pins[f]++;
        if (lru_mode) move_to_back(f);
        push_result(STAT_OK, f, 1'b0, '0, 1'b0, '0, 1'b1);
        return;
      end
      wr    = 1'b0;
      wpage = '0;
      f     = oldest_frame(1'b1);
      if (f < 0) begin
        f = oldest_frame(1'b0);
        if (f < 0) begin
          push_result(STAT_NO_FREE, 0, 1'b0, '0, 1'b0, '0, 1'b1);
          return;
        end
        // victim write-back rides on the same result as the read
        if (shadow_dirty[f]) begin
          wr    = 1'b1;
          wpage = shadow_page[f];
          writes_total++;
        end
      end
      shadow_page[f]  = page;
      shadow_valid[f] = 1'b1;
      shadow_dirty[f] = 1'b0;
      shadow_pins[f]  = PIN_BITS'(1);
      move_to_back(f);
      reads_total++;
      push_result(STAT_OK, f, 1'b1, page, wr, wpage, 1'b1);
    end else if (op == OP_FLUSH) begin
      // dirty unpinned frames, oldest first
      for (int r = 0; r < FRAMES; r++) begin
        for (int g = 0; g < FRAMES; g++) begin
          if (shadow_rank[g] == r && shadow_valid[g] && shadow_dirty[g] &&
              shadow_pins[g] == '0) flush_list.push_back(g);
        end
      end
      if (flush_list.size() == 0) begin
        push_result(STAT_OK, 0, 1'b0, '0, 1'b0, '0, 1'b1);
      end else begin
        foreach (flush_list[i]) begin
          shadow_dirty[flush_list[i]] = 1'b0;
          writes_total++;
          push_result(STAT_OK, flush_list[i], 1'b0, '0, 1'b1,
                      shadow_page[flush_list[i]], i == flush_list.size() - 1);
        end
      end
    end else if (op == OP_UNPIN || op == OP_DIRTY || op == OP_FORCE) begin
      f = find_resident(page);
      if (f < 0) begin
        push_result(STAT_NOT_RES, 0, 1'b0, '0, 1'b0, '0, 1'b1);
      end else if (op == OP_UNPIN) begin
        if (shadow_pins[f] != '0) shadow_pins[f]--;
        push_result(STAT_OK, f, 1'b0, '0, 1'b0, '0, 1'b1);
      end else if (op == OP_DIRTY) begin
        shadow_dirty[f] = 1'b1;
        push_result(STAT_OK, f, 1'b0, '0, 1'b0, '0, 1'b1);
      end else begin
        // force writes even clean or pinned frames
        shadow_dirty[f] = 1'b0;
        writes_total++;
        push_result(STAT_OK, f, 1'b0, '0, 1'b1, shadow_page[f], 1'b1);
      end
    end
    // unused op codes: no result, no state change
  endfunction

  // --------------------------------------------------------------------------
  // Input side: one request transfer, then maybe a random gap
  // --------------------------------------------------------------------------
  // Called right after a rising edge. Ready is sampled at the falling edge,
  // where it is settled, and the transfer lands on the following rising edge.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [PAGE_W-1:0] page);
    bit took;
    int gap;
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    page_number_i <= page;
    do begin
      @(negedge clk_i);
      took = (in_ready_o === 1'b1);
      @(posedge clk_i);
    end while (!took);
    predict_frame_op(op, page);
    if (op > OP_FLUSH) ignored_ops++;
    else transfers_in++;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      // some bursts run long with no idle at all
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(0, 7);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Stop sending, let every expected result drain, then let the block settle.
  task automatic wait_for_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup cycle, access cycle; pready is tied high in the block.
  task automatic write_strategy(input logic lru);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_STRATEGY;
    pwdata  <= APB_DW'(lru);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    lru_mode = lru;
  endtask

  // Working set: the pages now resident (so unpins can land), both extreme
  // page numbers, and a couple of fresh random pages.
  function automatic void refresh_hot_pages();
    for (int i = 0; i < HOT_PAGES; i++) begin
      if (i < FRAMES && shadow_valid[i]) hot_pages[i] = shadow_page[i];
      else hot_pages[i] = PAGE_W'($urandom);
    end
    hot_pages[FRAMES]     = PAGE_LOW;
    hot_pages[FRAMES + 1] = PAGE_HIGH;
  endfunction

  // Mostly well-formed traffic on the working set, some noise.
  task automatic send_random_request();
    int pick;
    logic [OP_W-1:0] op;
    logic [PAGE_W-1:0] page;
    pick = $urandom_range(0, 99);
    if (pick < 35)      op = OP_PIN;
    else if (pick < 68) op = OP_UNPIN;
    else if (pick < 80) op = OP_DIRTY;
    else if (pick < 87) op = OP_FORCE;
    else if (pick < 95) op = OP_FLUSH;
    else                op = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
    if ($urandom_range(0, 9) == 0) page = PAGE_W'($urandom);
    else page = hot_pages[$urandom_range(0, HOT_PAGES - 1)];
    send_request(op, page);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // FIFO basics: empty pool, misses, fill to full, all pinned, unpin at zero,
  // dirty and force, multi-result flush, dirty eviction, ignored op codes.
  task automatic test_directed_fifo();
    write_strategy(1'b0);
    send_request(OP_FLUSH, PAGE_LOW);   // nothing to flush
    send_request(OP_UNPIN, PAGE_LOW);   // page 0 is not resident after reset
    send_request(OP_DIRTY, PAGE_HIGH);
    send_request(OP_FORCE, PAGE_LOW);
    send_request(OP_PIN, PAGE_LOW);
    send_request(OP_PIN, PAGE_HIGH);
    send_request(OP_PIN, PAGE_LOW);     // hit, pins = 2
    for (int p = 100; p < 106; p++) send_request(OP_PIN, PAGE_W'(p));
    send_request(OP_PIN, PAGE_ALT);     // every frame pinned
    repeat (3) send_request(OP_UNPIN, PAGE_LOW);  // third one at zero
    send_request(OP_DIRTY, PAGE_LOW);
    send_request(OP_FORCE, PAGE_HIGH);  // pinned and clean, still written
    send_request(OP_DIRTY, PAGE_W'(101));
    send_request(OP_UNPIN, PAGE_W'(101));
    send_request(OP_FLUSH, PAGE_ALT);   // two write-backs
    send_request(OP_DIRTY, PAGE_LOW);
    send_request(OP_PIN, PAGE_ALTN);    // evicts page 0 with write-back
    send_request(OP_FIRST_UNUSED, PAGE_ALT);
    send_request(OP_FIRST_UNUSED + 1'b1, PAGE_ALTN);
    send_request(OP_LAST_CODE, PAGE_HIGH);
  endtask

  // LRU: a hit moves the frame to the back, so the victim differs from FIFO.
  task automatic test_directed_lru();
    wait_for_idle();
    write_strategy(1'b1);
    send_request(OP_UNPIN, PAGE_W'(100));
    send_request(OP_UNPIN, PAGE_W'(102));
    send_request(OP_UNPIN, PAGE_HIGH);
    send_request(OP_PIN, PAGE_W'(100));
    send_request(OP_PIN, PAGE_W'(400));
    send_request(OP_PIN, PAGE_W'(401));
    send_request(OP_UNPIN, PAGE_W'(100));
    send_request(OP_DIRTY, PAGE_W'(401));
    send_request(OP_UNPIN, PAGE_W'(401));
    send_request(OP_PIN, PAGE_HIGH);
  endtask

  task automatic test_random_mix(input logic lru, input int count);
    int start;
    wait_for_idle();
    write_strategy(lru);
    refresh_hot_pages();
    start = transfers_in;
    while (transfers_in - start < count) send_random_request();
  endtask

  // Result side holds off for a long stretch while requests keep coming,
  // so the output register fills and the block stops taking transfers.
  task automatic test_receiver_hold_off();
    -> hold_off_go;
    repeat (24) send_random_request();
  endtask

  // --------------------------------------------------------------------------
  // Result side: stall pattern plus the long hold-off
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(hold_off_go);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_active <= 1'b0;
    end
  end

  initial begin
    ready_mode_e mode;
    int mode_left;
    logic [31:0] stall_bits;
    mode       = READY_ALWAYS;
    mode_left  = 0;
    stall_bits = '0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode       = ready_mode_e'($urandom_range(0, 2));
        mode_left  = $urandom_range(16, 96);
        stall_bits = $urandom;
      end
      mode_left--;
      stall_bits = {stall_bits[30:0], stall_bits[31]};
      if (hold_active) begin
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          READY_ALWAYS:  out_ready_i <= 1'b1;
          READY_PATTERN: out_ready_i <= stall_bits[0];
          default:       out_ready_i <= stall_bits[1:0] == 2'b00;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: a transfer seen at the falling edge completes at the next
  // rising edge, and valid, ready and payload are all stable in between.
  // --------------------------------------------------------------------------
  initial begin
    frame_result_t seen;
    frame_result_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
        seen = '{status_o, frame_index_o, read_request_o, read_page_o, write_request_o,
                 write_page_o, last_o, read_total_o, write_total_o};
        results_checked++;
        if (pending_results.size() == 0) begin
          report_failure($sformatf("result %0d with nothing pending: st=%0d fr=%0d",
                                   results_checked, seen.status, seen.frame_index));
        end else begin
          want = pending_results.pop_front();
          if (seen.status !== want.status || seen.frame_index !== want.frame_index ||
              seen.rd_req !== want.rd_req || seen.rd_page !== want.rd_page ||
              seen.wr_req !== want.wr_req || seen.wr_page !== want.wr_page ||
              seen.last !== want.last || seen.rd_total !== want.rd_total ||
              seen.wr_total !== want.wr_total) begin
            report_failure($sformatf({"result %0d mismatch\n",
              "  exp st=%0d fr=%0d rd=%0b:%h wr=%0b:%h last=%0b tot=%0d/%0d\n",
              "  got st=%0d fr=%0d rd=%0b:%h wr=%0b:%h last=%0b tot=%0d/%0d"},
              results_checked,
              want.status, want.frame_index, want.rd_req, want.rd_page, want.wr_req,
              want.wr_page, want.last, want.rd_total, want.wr_total,
              seen.status, seen.frame_index, seen.rd_req, seen.rd_page, seen.wr_req,
              seen.wr_page, seen.last, seen.rd_total, seen.wr_total));
          end
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still pending",
             cycle_count, pending_results.size());
    $display("buffer_pool_replacement_tb failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    clear_shadow_table();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_fifo();
    test_directed_lru();
    test_random_mix(1'b0, 72);
    test_random_mix(1'b1, 72);
    test_receiver_hold_off();
    test_random_mix(1'b0, 72);
    test_random_mix(1'b1, 72);
    wait_for_idle();

    if (pending_results.size() != 0)
      report_failure($sformatf("%0d results never arrived", pending_results.size()));

    $display("run covered %0d requests (+%0d unused op codes) and %0d results, FIFO and LRU",
             transfers_in, ignored_ops, results_checked);
    $display("storage traffic predicted: %0d reads, %0d writes; %0d failures",
             reads_total, writes_total, failures);
    if (failures == 0) begin
      $display("buffer_pool_replacement_tb passed");
    end else begin
      $display("buffer_pool_replacement_tb failed");
    end
    $finish;
  end

endmodule
